### hw/rtl/prfl_pkg.sv
// Shared types and constants of the page frame replacement unit.
package prfl_pkg;

  // Fixed widths of the stream fields.
  localparam int unsigned PageInW   = 16;
  localparam int unsigned IdxW      = 6;
  localparam int unsigned CountW    = 16;
  localparam int unsigned OutDataW  = 40;

  // Default sizing of the frame set.
  localparam int unsigned DefFrames   = 4;
  localparam int unsigned DefPageBits = 16;

  // Replacement policy codes.
  typedef enum logic {
    POLICY_FIFO = 1'b0,
    POLICY_LRU  = 1'b1
  } policy_e;

  // Lookup results that ripple from cell to cell, lowest frame first.
  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] hit_idx;
    logic [IdxW-1:0] hit_rank;
    logic            empty;
    logic [IdxW-1:0] empty_idx;
    logic [IdxW-1:0] best_rank;
    logic [IdxW-1:0] best_idx;
  } chain_t;

  // Update command broadcast to every cell for one accepted beat.
  typedef struct packed {
    logic            en;
    logic            load;
    logic            promote;
    logic            age_all;
    logic [IdxW-1:0] idx;
    logic [IdxW-1:0] limit;
  } upd_t;

endpackage

### hw/rtl/prfl_cell.sv
// One frame cell: holds a page, a valid bit and an age rank, and extends the lookup chain.
module prfl_cell #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned RANK_W    = 2,
  parameter int unsigned PAGE_BITS = prfl_pkg::DefPageBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [PAGE_BITS-1:0]   page_i,
  input  prfl_pkg::chain_t       chain_i,
  output prfl_pkg::chain_t       chain_o,
  input  prfl_pkg::upd_t         upd_i,
  output logic [PAGE_BITS-1:0]   page_o,
  output logic                   valid_o,
  output logic                   hit_o
);

  localparam logic [prfl_pkg::IdxW-1:0] MyIdx = prfl_pkg::IdxW'(IDX);

  logic [PAGE_BITS-1:0] page_q;
  logic                 valid_q;
  logic [RANK_W-1:0]    rank_q, rank_d;
  logic [prfl_pkg::IdxW-1:0] rank_ext;
  logic                 sel;

  assign rank_ext = prfl_pkg::IdxW'(rank_q);
  assign hit_o    = valid_q && (page_q == page_i);
  assign page_o   = page_q;
  assign valid_o  = valid_q;
  assign sel      = (upd_i.idx == MyIdx);

  // Extend the chain: first hit, first empty frame and oldest rank win.
  always_comb begin
    chain_o = chain_i;
    if (!chain_i.hit && hit_o) begin
      chain_o.hit      = 1'b1;
      chain_o.hit_idx  = MyIdx;
      chain_o.hit_rank = rank_ext;
    end
    if (!chain_i.empty && !valid_q) begin
      chain_o.empty     = 1'b1;
      chain_o.empty_idx = MyIdx;
    end
    if (rank_ext > chain_i.best_rank) begin
      chain_o.best_rank = rank_ext;
      chain_o.best_idx  = MyIdx;
    end
  end

  // On a promote the selected frame becomes youngest; younger valid frames, or all on a fill, age by one.
  always_comb begin
    rank_d = rank_q;
    if (upd_i.en && upd_i.promote) begin
      if (sel) begin
        rank_d = '0;
      end else if (valid_q && (upd_i.age_all || (rank_ext < upd_i.limit))) begin
        rank_d = rank_q + RANK_W'(1);
      end
    end
  end

  // Control state of the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      rank_q <= rank_d;
      if (upd_i.en && upd_i.load && sel) begin
        valid_q <= 1'b1;
      end
    end
  end

  // Page payload is only read while the frame is valid.
  always_ff @(posedge clk_i) begin
    if (upd_i.en && upd_i.load && sel) begin
      page_q <= page_i;
    end
  end

endmodule

### hw/rtl/page_frame_replacement_fifo_lru.sv
// Top level of the page frame replacement unit with FIFO and LRU policies.
// A result beat is registered on the master side in the cycle after its reference is accepted.
// Throughput: one reference per cycle; the lookup ripples combinationally through FRAMES cells.
// The slave side stalls only while an earlier result beat waits on the master side.
// Reset empties all frames, clears ranks and the fault count, and selects FIFO policy.
module page_frame_replacement_fifo_lru #(
  parameter int unsigned FRAMES    = prfl_pkg::DefFrames,
  parameter int unsigned PAGE_BITS = prfl_pkg::DefPageBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel: policy_mode.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_data_i,
  // Reference stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [prfl_pkg::PageInW-1:0]   s_axis_tdata,  // [15:0] page_number
  // Result stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] page_fault, [6:1] frame_index, [7] evicted_valid,
  // [23:8] evicted_page, [39:24] fault_total
  output logic [prfl_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned IdxBits = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [prfl_pkg::CountW-1:0] CountMax = '1;

  prfl_pkg::policy_e         policy_q;
  prfl_pkg::chain_t          chain [FRAMES+1];
  prfl_pkg::upd_t            upd;
  logic [PAGE_BITS-1:0]      page_in;
  logic [PAGE_BITS-1:0]      cell_page [FRAMES];
  logic [FRAMES-1:0]         cell_valid;
  logic [FRAMES-1:0]         cell_hit;
  logic                      accept;
  logic                      fault, evict;
  logic [PAGE_BITS-1:0]      ev_page;
  logic [prfl_pkg::CountW-1:0] fault_q, fault_d;
  logic                      m_valid_q;
  logic [prfl_pkg::OutDataW-1:0] m_data_q, m_data_d;

  assign page_in       = PAGE_BITS'(s_axis_tdata);
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Policy register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= prfl_pkg::POLICY_FIFO;
    end else if (cfg_valid_i) begin
      policy_q <= prfl_pkg::policy_e'(cfg_data_i);
    end
  end

  // Lookup chain enters at frame zero with nothing found.
  assign chain[0] = '0;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    prfl_cell #(
      .IDX       (g),
      .RANK_W    (IdxBits),
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .page_i  (page_in),
      .chain_i (chain[g]),
      .chain_o (chain[g+1]),
      .upd_i   (upd),
      .page_o  (cell_page[g]),
      .valid_o (cell_valid[g]),
      .hit_o   (cell_hit[g])
    );
  end

  // Decide hit, fill of an empty frame or eviction of the oldest frame.
  always_comb begin
    upd         = '0;
    upd.en      = accept;
    fault       = 1'b0;
    evict       = 1'b0;
    ev_page     = '0;
    priority if (chain[FRAMES].hit) begin
      upd.idx     = chain[FRAMES].hit_idx;
      upd.limit   = chain[FRAMES].hit_rank;
      upd.promote = (policy_q == prfl_pkg::POLICY_LRU);
    end else if (chain[FRAMES].empty) begin
      fault       = 1'b1;
      upd.idx     = chain[FRAMES].empty_idx;
      upd.load    = 1'b1;
      upd.promote = 1'b1;
      upd.age_all = 1'b1;
    end else begin
      fault       = 1'b1;
      evict       = 1'b1;
      upd.idx     = chain[FRAMES].best_idx;
      upd.limit   = chain[FRAMES].best_rank;
      upd.load    = 1'b1;
      upd.promote = 1'b1;
      ev_page     = cell_page[chain[FRAMES].best_idx[IdxBits-1:0]];
    end
  end

  // Saturating fault count.
  always_comb begin
    fault_d = fault_q;
    if (accept && fault && (fault_q != CountMax)) begin
      fault_d = fault_q + prfl_pkg::CountW'(1);
    end
  end

  assign m_data_d = {fault_d, prfl_pkg::PageInW'(ev_page), evict, upd.idx, fault};

  // Fault counter and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      fault_q <= fault_d;
      if (accept) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Result beat payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_data_q <= m_data_d;
    end
  end

  // Resident pages are distinct, so at most one cell can hit.
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_hit))
    else $error("more than one frame hit");

  // An accepted reference always yields a result beat next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid)
    else $error("result beat missing after accept");

  // Eviction is only reported together with a fault.
  a_evict_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[7]) |-> m_axis_tdata[0])
    else $error("eviction without fault");

  // The fault count never decreases.
  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (fault_q >= $past(fault_q)))
    else $error("fault count decreased");

  // Once every frame is loaded, frames stay loaded.
  a_full_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&cell_valid) |=> (&cell_valid))
    else $error("frame lost its valid bit");

endmodule

### dv/tb_page_frame_replacement_fifo_lru.sv
// Self-checking testbench for the FIFO/LRU page frame replacement unit.
`timescale 1ns / 100ps

module tb_page_frame_replacement_fifo_lru;

  localparam int unsigned NFRAMES     = prfl_pkg::DefFrames;
  localparam logic [15:0] PAGE_MASK   = 16'((64'd1 << prfl_pkg::DefPageBits) - 1);
  localparam logic [15:0] COUNT_FULL  = 16'hFFFF;
  localparam int          STALL_LIMIT = 2000;
  localparam int          PHASE_ITEMS = 225;

  // One result beat, laid out as on m_axis_tdata.
  typedef struct packed {
    logic [15:0]               fault_total;
    logic [15:0]               evicted_page;
    logic                      evicted_valid;
    logic [prfl_pkg::IdxW-1:0] frame_index;
    logic                      page_fault;
  } frame_result_t;

  typedef enum logic {
    ROW_REF = 1'b0,
    ROW_CFG = 1'b1
  } row_kind_e;

  // One row of the directed sequence; pinned rows carry a hand-written result.
  typedef struct packed {
    row_kind_e                 kind;
    prfl_pkg::policy_e         policy;
    logic [15:0]               page;
    logic                      pinned;
    logic                      fault;
    logic [prfl_pkg::IdxW-1:0] idx;
    logic                      ev_valid;
    logic [15:0]               ev_page;
    logic [15:0]               total;
  } dir_row_t;

  localparam int DIR_N = 18;
  // Fill from empty in FIFO order, hit, evict the oldest, then switch policy mid-stream.
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{ROW_REF, prfl_pkg::POLICY_FIFO, 16'h0000, 1'b1, 1'b1, 6'd0, 1'b0, 16'h0000, 16'd1},
    '{ROW_REF, prfl_pkg::POLICY_FIFO, 16'hFFFF, 1'b1, 1'b1, 6'd1, 1'b0, 16'h0000, 16'd2},
    '{ROW_REF, prfl_pkg::POLICY_FIFO, 16'h0000, 1'b1, 1'b0, 6'd0, 1'b0, 16'h0000, 16'd2},
    '{ROW_REF, prfl_pkg::POLICY_FIFO, 16'h00FF, 1'b1, 1'b1, 6'd2, 1'b0, 16'h0000, 16'd3},
    '{ROW_REF, prfl_pkg::POLICY_FIFO, 16'hFF00, 1'b1, 1'b1, 6'd3, 1'b0, 16'h0000, 16'd4},
    '{ROW_REF, prfl_pkg::POLICY_FIFO, 16'h1234, 1'b1, 1'b1, 6'd0, 1'b1, 16'h0000, 16'd5},
    '{ROW_REF, prfl_pkg::POLICY_FIFO, 16'hFFFF, 1'b1, 1'b0, 6'd1, 1'b0, 16'h0000, 16'd5},
    '{ROW_REF, prfl_pkg::POLICY_FIFO, 16'hABCD, 1'b1, 1'b1, 6'd1, 1'b1, 16'hFFFF, 16'd6},
    '{ROW_CFG, prfl_pkg::POLICY_LRU,  16'h0000, 1'b0, 1'b0, 6'd0, 1'b0, 16'h0000, 16'd0},
    '{ROW_REF, prfl_pkg::POLICY_FIFO, 16'h00FF, 1'b0, 1'b0, 6'd0, 1'b0, 16'h0000, 16'd0},
    '{ROW_REF, prfl_pkg::POLICY_FIFO, 16'h5555, 1'b0, 1'b0, 6'd0, 1'b0, 16'h0000, 16'd0},
    '{ROW_REF, prfl_pkg::POLICY_FIFO, 16'h1234, 1'b0, 1'b0, 6'd0, 1'b0, 16'h0000, 16'd0},
    '{ROW_REF, prfl_pkg::POLICY_FIFO, 16'hAAAA, 1'b0, 1'b0, 6'd0, 1'b0, 16'h0000, 16'd0},
    '{ROW_REF, prfl_pkg::POLICY_FIFO, 16'h8001, 1'b0, 1'b0, 6'd0, 1'b0, 16'h0000, 16'd0},
    '{ROW_CFG, prfl_pkg::POLICY_FIFO, 16'h0000, 1'b0, 1'b0, 6'd0, 1'b0, 16'h0000, 16'd0},
    '{ROW_REF, prfl_pkg::POLICY_FIFO, 16'h5555, 1'b0, 1'b0, 6'd0, 1'b0, 16'h0000, 16'd0},
    '{ROW_REF, prfl_pkg::POLICY_FIFO, 16'h7FFE, 1'b0, 1'b0, 6'd0, 1'b0, 16'h0000, 16'd0},
    '{ROW_REF, prfl_pkg::POLICY_FIFO, 16'h0F0F, 1'b0, 1'b0, 6'd0, 1'b0, 16'h0000, 16'd0}
  };

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic                          cfg_data_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [prfl_pkg::PageInW-1:0]  s_axis_tdata;   // [15:0] page_number
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // [0] page_fault, [6:1] frame_index, [7] evicted_valid,
  // [23:8] evicted_page, [39:24] fault_total
  logic [prfl_pkg::OutDataW-1:0] m_axis_tdata;

  // Predicted frame table, policy and fault count.
  logic [15:0]       fr_page  [NFRAMES];
  logic              fr_valid [NFRAMES];
  int unsigned       fr_rank  [NFRAMES];
  logic [15:0]       fault_cnt;
  prfl_pkg::policy_e pred_policy;

  frame_result_t result_q [$];
  frame_result_t sb_got, sb_want;
  int            pending_n = 0;
  logic          cur_pinned;
  frame_result_t cur_pin_res;

  int          tx_gap_pct   = 0;
  int          rx_stall_pct = 0;
  int unsigned mismatches   = 0;
  int unsigned refs_seen    = 0;
  int unsigned faults_seen  = 0;
  int unsigned evicts_seen  = 0;
  int unsigned cfg_writes   = 0;
  int          quiet_cycles = 0;

  page_frame_replacement_fifo_lru #(
    .FRAMES    (prfl_pkg::DefFrames),
    .PAGE_BITS (prfl_pkg::DefPageBits)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 50 MHz clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Make frame k the youngest; valid frames younger than limit age by one.
  function automatic void age_frames(input int k, input int unsigned limit);
    for (int j = 0; j < NFRAMES; j++) begin
      if (j != k && fr_valid[j] && fr_rank[j] < limit) fr_rank[j] = fr_rank[j] + 1;
    end
    fr_rank[k] = 0;
  endfunction

  // Look up one reference, update the predicted table and return its result beat.
  function automatic frame_result_t lookup_page(input logic [15:0] raw_page);
    frame_result_t r;
    logic [15:0]   pg;
    int            k;
    int            best;
    bit            hit;
    bit            empty;
    r     = '0;
    pg    = raw_page & PAGE_MASK;
    k     = 0;
    hit   = 1'b0;
    empty = 1'b0;
    for (int j = 0; j < NFRAMES; j++) begin
      if (!hit && fr_valid[j] && fr_page[j] == pg) begin
        k   = j;
        hit = 1'b1;
      end
    end
    if (hit) begin
      if (pred_policy == prfl_pkg::POLICY_LRU) age_frames(k, fr_rank[k]);
    end else begin
      r.page_fault = 1'b1;
      for (int j = 0; j < NFRAMES; j++) begin
        if (!empty && !fr_valid[j]) begin
          k     = j;
          empty = 1'b1;
        end
      end
      if (empty) begin
        fr_valid[k] = 1'b1;
        fr_page[k]  = pg;
        age_frames(k, NFRAMES);
      end else begin
        // Oldest rank wins; ties keep the lowest index.
        best = 0;
        for (int j = 1; j < NFRAMES; j++) begin
          if (fr_rank[j] > fr_rank[best]) best = j;
        end
        k               = best;
        r.evicted_valid = 1'b1;
        r.evicted_page  = fr_page[k];
        fr_page[k]      = pg;
        age_frames(k, fr_rank[k]);
      end
      if (fault_cnt != COUNT_FULL) fault_cnt = fault_cnt + 16'd1;
    end
    r.frame_index = prfl_pkg::IdxW'(k);
    r.fault_total = fault_cnt;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatches < 40) begin
      $display("MISMATCH at result %0d: %s got 0x%0h want 0x%0h", refs_seen, what, got, want);
    end
    mismatches++;
  endtask

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Scoreboard: check result beats, track policy writes, predict accepted references.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb_got = m_axis_tdata;
        if (result_q.size() == 0) begin
          report_mismatch("result beat with nothing expected", 16'(sb_got.frame_index),
                          16'd0);
        end else begin
          sb_want = result_q.pop_front();
          if (sb_got.page_fault !== sb_want.page_fault)
            report_mismatch("page_fault", 16'(sb_got.page_fault), 16'(sb_want.page_fault));
          if (sb_got.frame_index !== sb_want.frame_index)
            report_mismatch("frame_index", 16'(sb_got.frame_index),
                            16'(sb_want.frame_index));
          if (sb_got.evicted_valid !== sb_want.evicted_valid)
            report_mismatch("evicted_valid", 16'(sb_got.evicted_valid),
                            16'(sb_want.evicted_valid));
          if (sb_got.evicted_page !== sb_want.evicted_page)
            report_mismatch("evicted_page", sb_got.evicted_page, sb_want.evicted_page);
          if (sb_got.fault_total !== sb_want.fault_total)
            report_mismatch("fault_total", sb_got.fault_total, sb_want.fault_total);
        end
        refs_seen++;
        if (sb_got.page_fault === 1'b1) faults_seen++;
        if (sb_got.evicted_valid === 1'b1) evicts_seen++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        pred_policy = prfl_pkg::policy_e'(cfg_data_i);
        cfg_writes++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb_want = lookup_page(s_axis_tdata);
        if (cur_pinned) sb_want = cur_pin_res;
        result_q.push_back(sb_want);
      end
      pending_n <= pending_n + int'(s_axis_tvalid && s_axis_tready)
                             - int'(m_axis_tvalid && m_axis_tready);
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one reference beat, with random idle cycles ahead of it.
  task automatic send_ref(input logic [15:0] pg, input logic pinned,
                          input frame_result_t pin_res);
    while ($urandom_range(99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pg;
    cur_pinned    <= pinned;
    cur_pin_res   <= pin_res;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop sending and wait until every outstanding result beat has arrived.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_n != 0);
  endtask

  // Write the policy register; only called while the unit is idle.
  task automatic write_policy(input prfl_pkg::policy_e pol);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= pol;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Random references drawn mostly from a small working set so hits and evictions mix.
  task automatic run_random(input int n_items, input int gap_pct, input int stall_pct);
    logic [15:0] pool [8];
    int          pool_n;
    logic [15:0] pg;
    pool_n     = 3;
    tx_gap_pct = gap_pct;
    rx_stall_pct <= stall_pct;
    for (int n = 0; n < n_items; n++) begin
      if (n % 40 == 0) begin
        pool_n = $urandom_range(8, 3);
        for (int j = 0; j < 8; j++) pool[j] = 16'($urandom);
        if ($urandom_range(3) == 0) pool[0] = 16'h0000;
        if ($urandom_range(3) == 0) pool[1] = 16'hFFFF;
      end
      if ($urandom_range(79) == 0) wait_idle();
      if ($urandom_range(9) == 0) pg = 16'($urandom);
      else pg = pool[$urandom_range(pool_n - 1)];
      send_ref(pg, 1'b0, '0);
    end
  endtask

  initial begin
    frame_result_t pin;
    int            gaps   [4];
    int            stalls [4];
    gaps   = '{0, 53, 0, 21};
    stalls = '{0, 0, 53, 21};

    // Predictor reset state.
    for (int j = 0; j < NFRAMES; j++) begin
      fr_page[j]  = '0;
      fr_valid[j] = 1'b0;
      fr_rank[j]  = 0;
    end
    fault_cnt   = '0;
    pred_policy = prfl_pkg::POLICY_FIFO;

    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cur_pinned    = 1'b0;
    cur_pin_res   = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sequence.
    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        wait_idle();
        write_policy(DIR_ROWS[i].policy);
      end else begin
        pin.page_fault    = DIR_ROWS[i].fault;
        pin.frame_index   = DIR_ROWS[i].idx;
        pin.evicted_valid = DIR_ROWS[i].ev_valid;
        pin.evicted_page  = DIR_ROWS[i].ev_page;
        pin.fault_total   = DIR_ROWS[i].total;
        send_ref(DIR_ROWS[i].page, DIR_ROWS[i].pinned, pin);
      end
    end

    // Random phases: every idling pattern under both policies.
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_policy((p % 2 == 0) ? prfl_pkg::POLICY_LRU : prfl_pkg::POLICY_FIFO);
      run_random(PHASE_ITEMS, gaps[p / 2], stalls[p / 2]);
    end

    // Short closing run under LRU with both sides idling.
    wait_idle();
    write_policy(prfl_pkg::POLICY_LRU);
    run_random(60, 21, 21);

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (result_q.size() != 0) begin
      report_mismatch("expected results never arrived", 16'(result_q.size()), 16'd0);
    end

    $display("Covered %0d references (%0d faults, %0d evictions) over %0d policy writes,",
             refs_seen, faults_seen, evicts_seen, cfg_writes);
    $display("every idle pattern under both policies, draining to empty before each write.");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
